// ===== design/gcwp_pkg.sv =====
`default_nettype none
package gcwp_pkg;

	localparam int OFFSET_BITS = 20;
	localparam int LIMIT_W = 16;
	localparam int LPP_W = 10;
	localparam int SUM_W = 17;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam int MAX_RESULTS = 4;
	localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);
	localparam int QUEUE_DEPTH = 2 * MAX_RESULTS;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd480;
	localparam logic [LPP_W-1:0] LPP_RESET = 10'd20;

	localparam logic [7:0] CHAR_LF = 8'd10;
	localparam logic [7:0] CHAR_CR = 8'd13;

	typedef logic [OFFSET_BITS-1:0] offset_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_WIDTH_LIMIT = 1'b0,
		CFG_LINES_PER_PAGE = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		KIND_CHAR = 1'b0,
		KIND_PAGE = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] out_char;
		offset_t wrapped_offset;
		offset_t source_offset;
		logic last_of_run;
	} result_t;

	// saturating offset increment
	function automatic offset_t sat_inc(input offset_t v);
		offset_t r;
		r = (v == '1) ? v : v + offset_t'(1);
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/gcwp_char_if.sv =====
`default_nettype none
interface gcwp_char_if;
	logic valid;
	logic ready;
	logic [7:0] char_code;
	logic [7:0] char_width;
	logic end_of_text;

	modport source(output valid, output char_code, output char_width, output end_of_text,
		input ready);
	modport sink(input valid, input char_code, input char_width, input end_of_text,
		output ready);
endinterface
`default_nettype wire

// ===== design/gcwp_res_if.sv =====
`default_nettype none
interface gcwp_res_if
	import gcwp_pkg::*;
	;
	logic valid;
	logic ready;
	kind_t kind;
	logic [7:0] out_char;
	offset_t wrapped_offset;
	offset_t source_offset;
	logic last_of_run;

	modport source(output valid, output kind, output out_char, output wrapped_offset,
		output source_offset, output last_of_run, input ready);
	modport sink(input valid, input kind, input out_char, input wrapped_offset,
		input source_offset, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== design/greedy_char_wrap_paginator_unit.sv =====
`default_nettype none
// Greedy character-wrap paginator. Each request on chars carries one Latin-1
// character, its pixel width and an end-of-text mark; the unit passes the
// character on (carriage returns are dropped), inserts a line feed ahead of any
// character that would push the line past line_width_limit, and emits a page
// record (wrapped and source offsets) every lines_per_page lines plus a closing
// record at end of text unless the last record's wrapped offset equals the input
// length. Each character makes zero to four result requests on results (a carriage
// return with no record makes none). All of one character's work is done in the
// accept cycle and its results land in an 8-entry result queue, so chars takes a new
// request every cycle while at most four results are queued: plain text runs at one
// character per cycle, and each further result (inserted line feed, page or closing
// record) stalls chars only once the queue backs up. Write the registers through
// cfg_we/cfg_index/cfg_data only while the unit is idle; the unit does not check.
module greedy_char_wrap_paginator_unit
	import gcwp_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	gcwp_char_if.sink chars,
	gcwp_res_if.source results,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	// config registers
	logic [LIMIT_W-1:0] limit_q;
	logic [LPP_W-1:0] lpp_q;

	// running state
	logic [SUM_W-1:0] sum_q;
	logic [LPP_W-1:0] lines_q;
	offset_t out_cnt_q;
	offset_t in_cnt_q;
	offset_t line_start_q;
	offset_t last_rec_q;

	// result queue, head at entry 0
	result_t queue_q [QUEUE_DEPTH];
	result_t queue_d [QUEUE_DEPTH];
	result_t shifted [QUEUE_DEPTH];
	logic [QCNT_W-1:0] qcnt_q;
	logic [QCNT_W-1:0] qcnt_d;
	logic [QCNT_W-1:0] base;

	logic accept;
	logic pop;

	// per-character datapath
	logic is_lf;
	logic is_cr;
	logic emit;
	logic wrap;
	logic page;
	logic close;
	logic [SUM_W-1:0] sum_add;
	logic [SUM_W-1:0] sum_d;
	logic [LPP_W-1:0] lines1;
	logic [LPP_W-1:0] lines_d;
	offset_t oc1;
	offset_t oc2;
	offset_t lso1;
	offset_t lso2;
	offset_t lro_d;
	offset_t ic1;

	result_t raw_res [MAX_RESULTS];
	logic [MAX_RESULTS-1:0] raw_vld;
	logic [RES_CNT_W-1:0] raw_pos [MAX_RESULTS];
	result_t packed_res [MAX_RESULTS];
	logic [RES_CNT_W-1:0] nres;

	assign accept = chars.valid && chars.ready;
	assign pop = results.valid && results.ready;

	// room for a worst-case character even if nothing drains this cycle
	assign chars.ready = (qcnt_q <= QCNT_W'(MAX_RESULTS));

	always_comb begin
		is_lf = (chars.char_code == CHAR_LF);
		is_cr = (chars.char_code == CHAR_CR);
		emit = !is_cr;
		sum_add = sum_q + {{(SUM_W-8){1'b0}}, chars.char_width};
		wrap = !is_lf && !is_cr && (sum_add > {1'b0, limit_q});

		lines1 = (is_lf || wrap) ? lines_q + LPP_W'(1) : lines_q;
		oc1 = wrap ? sat_inc(out_cnt_q) : out_cnt_q;
		lso1 = wrap ? oc1 : line_start_q;
		oc2 = emit ? sat_inc(oc1) : oc1;
		lso2 = is_lf ? oc2 : lso1;

		if (is_lf) begin
			sum_d = '0;
		end else if (is_cr) begin
			sum_d = sum_q;
		end else if (wrap) begin
			sum_d = {{(SUM_W-8){1'b0}}, chars.char_width};
		end else begin
			sum_d = sum_add;
		end

		page = (lines1 >= lpp_q);
		lines_d = page ? '0 : lines1;
		lro_d = page ? lso2 : last_rec_q;
		ic1 = sat_inc(in_cnt_q);
		// output offset compared with input length, as specified
		close = chars.end_of_text && (lro_d != ic1);
	end

	// candidate results in emission order: wrap LF, character, page, closing
	always_comb begin
		raw_vld = {close, page, emit, wrap};

		raw_res[0] = '{kind: KIND_CHAR, out_char: CHAR_LF, wrapped_offset: '0,
			source_offset: '0, last_of_run: 1'b0};
		raw_res[1] = '{kind: KIND_CHAR, out_char: chars.char_code, wrapped_offset: '0,
			source_offset: '0, last_of_run: 1'b0};
		raw_res[2] = '{kind: KIND_PAGE, out_char: '0, wrapped_offset: lso2,
			source_offset: in_cnt_q, last_of_run: 1'b0};
		raw_res[3] = '{kind: KIND_PAGE, out_char: '0, wrapped_offset: oc2,
			source_offset: ic1, last_of_run: 1'b0};

		raw_pos[0] = '0;
		for (int i = 1; i < MAX_RESULTS; i++) begin
			raw_pos[i] = raw_pos[i-1] + RES_CNT_W'(raw_vld[i-1]);
		end
		nres = raw_pos[MAX_RESULTS-1] + RES_CNT_W'(raw_vld[MAX_RESULTS-1]);

		// pack valid results to the front, tag the final one
		for (int j = 0; j < MAX_RESULTS; j++) begin
			packed_res[j] = raw_res[MAX_RESULTS-1];
			for (int i = 0; i < MAX_RESULTS; i++) begin
				if (raw_vld[i] && raw_pos[i] == RES_CNT_W'(j)) begin
					packed_res[j] = raw_res[i];
				end
			end
			packed_res[j].last_of_run = (RES_CNT_W'(j + 1) == nres);
		end
	end

	// queue next-state: drop head on pop, append new results behind survivors
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
			shifted[i] = pop ? queue_q[i+1] : queue_q[i];
		end
		shifted[QUEUE_DEPTH-1] = queue_q[QUEUE_DEPTH-1];

		base = qcnt_q - QCNT_W'(pop);
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			logic [QCNT_W-1:0] rel;
			rel = QCNT_W'(i) - base;
			queue_d[i] = shifted[i];
			if (accept && QCNT_W'(i) >= base && rel < QCNT_W'(nres)) begin
				queue_d[i] = packed_res[rel[RES_CNT_W-2:0]];
			end
		end
		qcnt_d = base + (accept ? QCNT_W'(nres) : '0);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			queue_q[i] <= queue_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q <= '0;
		end else begin
			qcnt_q <= qcnt_d;
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			lpp_q <= LPP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINE_WIDTH_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_LINES_PER_PAGE: lpp_q <= cfg_data[LPP_W-1:0];
				default: ;
			endcase
		end
	end

	// running state; end of text returns it to zero for the next text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			lines_q <= '0;
			out_cnt_q <= '0;
			in_cnt_q <= '0;
			line_start_q <= '0;
			last_rec_q <= '0;
		end else if (accept) begin
			if (chars.end_of_text) begin
				sum_q <= '0;
				lines_q <= '0;
				out_cnt_q <= '0;
				in_cnt_q <= '0;
				line_start_q <= '0;
				last_rec_q <= '0;
			end else begin
				sum_q <= sum_d;
				lines_q <= lines_d;
				out_cnt_q <= oc2;
				in_cnt_q <= ic1;
				line_start_q <= lso2;
				last_rec_q <= lro_d;
			end
		end
	end

	assign results.valid = (qcnt_q != '0);
	assign results.kind = queue_q[0].kind;
	assign results.out_char = queue_q[0].out_char;
	assign results.wrapped_offset = queue_q[0].wrapped_offset;
	assign results.source_offset = queue_q[0].source_offset;
	assign results.last_of_run = queue_q[0].last_of_run;

	// queue never overfills
	a_qcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overflow");

	// every accepted character other than CR produces at least one result
	a_non_cr_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_cr |-> nres != '0)
		else $error("non-CR character produced no result");

	// end of text leaves clean state
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && chars.end_of_text |=> in_cnt_q == '0 && lines_q == '0 && sum_q == '0)
		else $error("state not cleared after end of text");

	// a page record goes out with the line counter restarted
	a_page_resets_lines: assert property (@(posedge clk) disable iff (!arst_n)
		accept && page && !chars.end_of_text |=> lines_q == '0)
		else $error("line count not restarted after page record");

endmodule
`default_nettype wire

// ===== verif/greedy_char_wrap_paginator_unit_test.sv =====
`timescale 1ns / 100ps
module greedy_char_wrap_paginator_unit_test;
	import gcwp_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 8;    // idle pad before a register write
	localparam int unsigned END_CYCLES = 16;      // quiet time at end of run
	localparam int unsigned STUCK_LIMIT = 2000;   // cycles with no handshake at all
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned PHASE_CHARS = 58;
	localparam int unsigned MAX_REPORTS = 20;

	// one row of the directed table; typed rows carry their results inline
	typedef struct {
		bit is_cfg;
		cfg_idx_t idx;
		logic [CFG_DATA_W-1:0] data;
		logic [7:0] code;
		logic [7:0] px;
		logic eot;
		bit typed;
		int unsigned n;
		result_t res [MAX_RESULTS];
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gcwp_char_if chars_if();
	gcwp_res_if res_if();

	greedy_char_wrap_paginator_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars_if),
		.results(res_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Paginator shadow: register copies and running state
	// ---------------------------------------------------------------
	logic [LIMIT_W-1:0] cfg_limit = LIMIT_RESET;
	logic [LPP_W-1:0] cfg_lpp = LPP_RESET;
	logic [SUM_W-1:0] line_px = '0;
	logic [LPP_W-1:0] page_lines = '0;
	offset_t out_off = '0;
	offset_t in_off = '0;
	offset_t line_start = '0;
	offset_t last_rec = '0;

	result_t fresh_q [$];           // results of the request just taken
	result_t wrapped_stream_q [$];  // results still owed by the DUT
	step_t plan [$];                // directed table
	step_t live_step;               // sideband riding along with the current request

	int unsigned mismatches = 0;
	int unsigned stuck_cycles = 0;
	int unsigned burst_left = 0;
	bit steady = 1'b0;

	function automatic offset_t step_offset(input offset_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void push_glyph(input logic [7:0] c);
		result_t r;
		r = {KIND_CHAR, c, offset_t'(0), offset_t'(0), 1'b0};
		fresh_q.push_back(r);
		out_off = step_offset(out_off);
	endfunction

	function automatic void push_record(input offset_t wo, input offset_t so);
		result_t r;
		r = {KIND_PAGE, 8'd0, wo, so, 1'b0};
		fresh_q.push_back(r);
	endfunction

	// Greedy wrap + page accounting for one character
	function automatic void paginate_char(input logic [7:0] code, input logic [7:0] px,
		input logic eot);
		offset_t here;
		here = in_off;
		fresh_q.delete();
		if (code == CHAR_LF) begin
			line_px = '0;
			page_lines = page_lines + 1'b1;
			push_glyph(CHAR_LF);
			line_start = out_off;
		end else if (code != CHAR_CR) begin
			line_px = line_px + px;
			if (line_px > {1'b0, cfg_limit}) begin
				// wrap: inserted LF, new line begins with this glyph's width
				line_px = SUM_W'(px);
				page_lines = page_lines + 1'b1;
				push_glyph(CHAR_LF);
				line_start = out_off;
			end
			push_glyph(code);
		end
		// page check runs for CR too
		if (page_lines >= cfg_lpp) begin
			page_lines = '0;
			push_record(line_start, here);
			last_rec = line_start;
		end
		in_off = step_offset(in_off);
		if (eot) begin
			// closing record skipped when last record offset equals input length
			if (last_rec != in_off)
				push_record(out_off, in_off);
			line_px = '0;
			page_lines = '0;
			out_off = '0;
			in_off = '0;
			line_start = '0;
			last_rec = '0;
		end
		if (fresh_q.size() != 0)
			fresh_q[fresh_q.size() - 1].last_of_run = 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// Directed table builders
	// ---------------------------------------------------------------
	function automatic step_t char_step(input logic [7:0] c, input logic [7:0] px,
		input logic eot, input bit typed);
		step_t s;
		s.is_cfg = 1'b0;
		s.idx = CFG_LINE_WIDTH_LIMIT;
		s.data = '0;
		s.code = c;
		s.px = px;
		s.eot = eot;
		s.typed = typed;
		s.n = 0;
		return s;
	endfunction

	function automatic step_t cfg_step(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		step_t s;
		s = char_step(8'd0, 8'd0, 1'b0, 1'b0);
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.data = d;
		return s;
	endfunction

	// append a typed result to the newest row; last_of_run moves to it
	function automatic void note_result(input kind_t k, input logic [7:0] c,
		input offset_t wo, input offset_t so);
		int unsigned i;
		i = plan.size() - 1;
		if (plan[i].n != 0)
			plan[i].res[plan[i].n - 1].last_of_run = 1'b0;
		plan[i].res[plan[i].n] = {k, c, wo, so, 1'b1};
		plan[i].n++;
	endfunction

	// ---------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------
	// one char request; sender runs in bursts with random gaps between them unless steady is set
	task automatic offer_char(input step_t s);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady) begin
				chars_if.valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
		end
		burst_left--;
		chars_if.valid <= 1'b1;
		chars_if.char_code <= s.code;
		chars_if.char_width <= s.px;
		chars_if.end_of_text <= s.eot;
		live_step <= s;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
	endtask

	// hold off the sender until every owed result is in, then pad
	task automatic drain(input int unsigned pad);
		chars_if.valid <= 1'b0;
		@(posedge clk);
		while (wrapped_stream_q.size() != 0) @(posedge clk);
		repeat (pad) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_LINE_WIDTH_LIMIT: cfg_limit = d;
			CFG_LINES_PER_PAGE: cfg_lpp = d[LPP_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// receiver: ready runs of random length, long ready stretches now and then
	initial begin
		int unsigned run;
		res_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
			res_if.ready <= 1'b1;
			repeat (run) @(posedge clk);
			res_if.ready <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	end

	// ---------------------------------------------------------------
	// Checking and watchdog
	// ---------------------------------------------------------------
	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	result_t head_exp;

	always @(posedge clk) begin
		if (arst_n) begin
			// predict first so a same-edge result still finds its expectation
			if (chars_if.valid && chars_if.ready) begin
				paginate_char(chars_if.char_code, chars_if.char_width, chars_if.end_of_text);
				if (live_step.typed) begin
					for (int i = 0; i < live_step.n; i++)
						wrapped_stream_q.push_back(live_step.res[i]);
				end else begin
					foreach (fresh_q[i])
						wrapped_stream_q.push_back(fresh_q[i]);
				end
			end
			if (res_if.valid && res_if.ready) begin
				if (wrapped_stream_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected result, expected none, actual kind=%0d char=%0d woff=%0d soff=%0d",
							$time, res_if.kind, res_if.out_char, res_if.wrapped_offset,
							res_if.source_offset);
				end else begin
					head_exp = wrapped_stream_q.pop_front();
					check_field("kind", 32'(head_exp.kind), 32'(res_if.kind));
					check_field("out_char", 32'(head_exp.out_char), 32'(res_if.out_char));
					check_field("wrapped_offset", 32'(head_exp.wrapped_offset),
						32'(res_if.wrapped_offset));
					check_field("source_offset", 32'(head_exp.source_offset),
						32'(res_if.source_offset));
					check_field("last_of_run", 32'(head_exp.last_of_run), 32'(res_if.last_of_run));
				end
			end
		end
		if ((chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		int unsigned r;
		int unsigned text_left;
		logic [7:0] c;
		logic [7:0] w;
		logic e;
		logic [LIMIT_W-1:0] lim;
		logic [LPP_W-1:0] lpp;

		chars_if.valid <= 1'b0;
		chars_if.char_code <= '0;
		chars_if.char_width <= '0;
		chars_if.end_of_text <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_LINE_WIDTH_LIMIT;
		cfg_data <= '0;
		live_step <= char_step(8'd0, 8'd0, 1'b0, 1'b0);

		// reset values: limit 480, 20 lines per page
		plan.push_back(char_step(8'd65, 8'd8, 1'b0, 1'b1));
		note_result(KIND_CHAR, 8'd65, 0, 0);
		plan.push_back(char_step(CHAR_CR, 8'd255, 1'b0, 1'b1));  // CR: nothing out
		plan.push_back(char_step(CHAR_LF, 8'd0, 1'b0, 1'b1));
		note_result(KIND_CHAR, CHAR_LF, 0, 0);
		plan.push_back(char_step(8'd255, 8'd255, 1'b0, 1'b1));
		note_result(KIND_CHAR, 8'd255, 0, 0);
		plan.push_back(char_step(8'd0, 8'd255, 1'b0, 1'b1));     // 510 > 480: wrap
		note_result(KIND_CHAR, CHAR_LF, 0, 0);
		note_result(KIND_CHAR, 8'd0, 0, 0);
		plan.push_back(char_step(8'd120, 8'd0, 1'b1, 1'b1));     // closing record
		note_result(KIND_CHAR, 8'd120, 0, 0);
		note_result(KIND_PAGE, 8'd0, 6, 6);
		// one line per page; upper data bits must be dropped
		plan.push_back(cfg_step(CFG_LINES_PER_PAGE, 16'hFC01));
		plan.push_back(char_step(8'd66, 8'd1, 1'b0, 1'b1));
		note_result(KIND_CHAR, 8'd66, 0, 0);
		plan.push_back(char_step(CHAR_LF, 8'd0, 1'b0, 1'b1));
		note_result(KIND_CHAR, CHAR_LF, 0, 0);
		note_result(KIND_PAGE, 8'd0, 2, 1);
		plan.push_back(char_step(8'd67, 8'd1, 1'b1, 1'b1));
		note_result(KIND_CHAR, 8'd67, 0, 0);
		note_result(KIND_PAGE, 8'd0, 3, 3);
		// last record offset equals input length: no closing record
		plan.push_back(char_step(CHAR_LF, 8'd0, 1'b1, 1'b1));
		note_result(KIND_CHAR, CHAR_LF, 0, 0);
		note_result(KIND_PAGE, 8'd0, 1, 0);
		// zero limit, zero lines per page
		plan.push_back(cfg_step(CFG_LINE_WIDTH_LIMIT, 16'd0));
		plan.push_back(cfg_step(CFG_LINES_PER_PAGE, 16'd0));
		plan.push_back(char_step(8'd68, 8'd0, 1'b0, 1'b1));      // zero width: no wrap
		note_result(KIND_CHAR, 8'd68, 0, 0);
		note_result(KIND_PAGE, 8'd0, 0, 0);
		plan.push_back(char_step(8'd69, 8'd1, 1'b1, 1'b1));
		note_result(KIND_CHAR, CHAR_LF, 0, 0);
		note_result(KIND_CHAR, 8'd69, 0, 0);
		note_result(KIND_PAGE, 8'd0, 2, 1);
		plan.push_back(char_step(CHAR_CR, 8'd0, 1'b0, 1'b1));    // CR still pages
		note_result(KIND_PAGE, 8'd0, 0, 0);
		plan.push_back(char_step(8'd70, 8'd5, 1'b1, 1'b1));      // all four results
		note_result(KIND_CHAR, CHAR_LF, 0, 0);
		note_result(KIND_CHAR, 8'd70, 0, 0);
		note_result(KIND_PAGE, 8'd0, 1, 1);
		note_result(KIND_PAGE, 8'd0, 2, 2);
		// top of both ranges
		plan.push_back(cfg_step(CFG_LINE_WIDTH_LIMIT, 16'hFFFF));
		plan.push_back(cfg_step(CFG_LINES_PER_PAGE, 16'hFFFF));
		plan.push_back(char_step(8'd255, 8'd255, 1'b1, 1'b1));
		note_result(KIND_CHAR, 8'd255, 0, 0);
		note_result(KIND_PAGE, 8'd0, 1, 1);
		plan.push_back(char_step(CHAR_CR, 8'd0, 1'b0, 1'b0));
		plan.push_back(char_step(CHAR_LF, 8'd255, 1'b0, 1'b0));
		plan.push_back(char_step(8'd122, 8'd128, 1'b1, 1'b0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain(SETTLE_CYCLES);
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				offer_char(plan[i]);
			end
		end

		// random texts, one register setting per phase
		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			drain(SETTLE_CYCLES);
			case (p)
				0: begin lim = LIMIT_RESET; lpp = LPP_RESET; end
				1: begin lim = 16'd1; lpp = 10'd1; end
				2: begin lim = 16'd0; lpp = 10'd0; end
				3: begin lim = 16'hFFFF; lpp = 10'h3FF; end
				7: begin lim = 16'($urandom_range(200, 2000)); lpp = 10'($urandom_range(0, 12)); end
				default: begin lim = 16'($urandom_range(0, 700)); lpp = 10'($urandom_range(1, 6)); end
			endcase
			write_reg(CFG_LINE_WIDTH_LIMIT, lim);
			write_reg(CFG_LINES_PER_PAGE, {6'($urandom), lpp});
			steady = (p == 3);  // back-to-back requests for one phase
			text_left = 0;
			for (int unsigned k = 0; k < PHASE_CHARS; k++) begin
				if (text_left == 0)
					text_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
						: $urandom_range(1, 30);
				text_left--;
				r = $urandom_range(0, 99);
				if (r < 9)
					c = CHAR_LF;
				else if (r < 14)
					c = CHAR_CR;
				else
					c = 8'($urandom_range(0, 255));
				r = $urandom_range(0, 9);
				w = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255));
				// stray end marks cut texts short
				e = (text_left == 0) || ($urandom_range(0, 49) == 0);
				if (e)
					text_left = 0;
				offer_char(char_step(c, w, e, 1'b0));
				// mid-text pause until the result side is empty
				if (p == 2 && k == 29)
					drain(0);
			end
		end

		drain(END_CYCLES);
		if (wrapped_stream_q.size() != 0) begin
			mismatches++;
			$display("%0t: %0d results still owed", $time, wrapped_stream_q.size());
		end
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
